@@ src/rce_pkg.sv @@
// Shared types and constants for the Roberts/Canny edge stream.
// Used by rce_grad, rce_thr and roberts_canny_edge_stream; depends on nothing.
package rce_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = 11;
  localparam int HGT_W     = 12;
  localparam int ROW_W     = 13;
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH   = 2'd3;

  localparam logic [WID_W-1:0] WIDTH_MIN   = 11'd3;
  localparam logic [WID_W-1:0] WIDTH_MAX   = 11'(MAX_WIDTH);
  localparam logic [HGT_W-1:0] HEIGHT_MIN  = 12'd3;
  localparam logic [PIX_W-1:0] EDGE_ON     = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_OFF    = 8'd0;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_t;

  // Position flags of one item, worked out when it is taken in.
  typedef struct packed {
    logic out_ok;
    logic last;
    logic border_g;
    logic border_s;
    logic border_q;
  } pos_t;

  // One column entry of the magnitude store: the newer line and the one above it.
  typedef struct packed {
    pix_t mag_new;
    logic dir_new;
    pix_t mag_old;
  } mag_word_t;

  typedef struct packed {
    pix_t sup_new;
    pix_t sup_old;
  } sup_word_t;

  // Neighbourhood handed from the gradient stage to the suppression stage.
  typedef struct packed {
    pix_t m;
    logic dir;
    pix_t up;
    pix_t dn;
    pix_t lf;
    pix_t rt;
  } sup_in_t;

endpackage

@@ src/rce_grad.sv @@
// Gradient stage: pixel line store, Roberts gradient and magnitude line store.
// Depends on rce_pkg.
module rce_grad (
  input  logic            clk,
  input  logic            acc,
  input  rce_pkg::col_t   rd_col,
  input  rce_pkg::pix_t   pixel_in,
  input  logic            adv1,
  input  rce_pkg::col_t   wr_col,
  input  logic            border_g,
  output rce_pkg::sup_in_t sup_in
);
  import rce_pkg::*;

  pix_t      pix_mem [MAX_WIDTH];
  mag_word_t mag_mem [MAX_WIDTH];

  pix_t      pix_rd_r;
  pix_t      pix_cur_r;
  pix_t      pix_prev_r;
  pix_t      rd_prev_r;
  mag_word_t mag_rd_r;
  mag_word_t mag1_r;
  pix_t      mag2_r;

  pix_t       a, b, c, d;
  pix_t       ax, ay;
  logic [8:0] sum;
  pix_t       mag_g;
  logic       dir_g;
  mag_word_t  wword;

  always_ff @(posedge clk) begin
    if (acc) begin
      pix_mem[rd_col] <= pixel_in;
      pix_rd_r        <= pix_mem[rd_col];
      pix_cur_r       <= pixel_in;
      mag_rd_r        <= mag_mem[rd_col];
    end
    if (adv1) begin
      pix_prev_r      <= pix_cur_r;
      rd_prev_r       <= pix_rd_r;
      mag1_r          <= mag_rd_r;
      mag2_r          <= mag1_r.mag_new;
      mag_mem[wr_col] <= wword;
    end
  end

  // a and b lie one row above c and d; the gradient belongs to a.
  always_comb begin
    a     = rd_prev_r;
    b     = pix_rd_r;
    c     = pix_prev_r;
    d     = pix_cur_r;
    ax    = (d >= a) ? d - a : a - d;
    ay    = (c >= b) ? c - b : b - c;
    sum   = {1'b0, ax} + {1'b0, ay};
    mag_g = border_g ? a : sum[7:0];
    dir_g = border_g ? 1'b0 : ((c > b) || ((c == b) && (d < a)));
    wword = '{mag_new: mag_g, dir_new: dir_g, mag_old: mag1_r.mag_new};
    sup_in = '{m: mag1_r.mag_new, dir: mag1_r.dir_new, up: mag1_r.mag_old,
               dn: mag_g, lf: mag2_r, rt: mag_rd_r.mag_new};
  end

endmodule

@@ src/rce_thr.sv @@
// Suppression and double threshold, with the suppressed line store and output register.
// Depends on rce_pkg.
module rce_thr (
  input  logic             clk,
  input  logic             acc,
  input  rce_pkg::col_t    rd_col,
  input  logic             adv1,
  input  logic             adv2,
  input  rce_pkg::col_t    wr_col1,
  input  rce_pkg::pos_t    pos1,
  input  rce_pkg::sup_in_t sup_in,
  input  rce_pkg::pix_t    low_thr,
  input  rce_pkg::pix_t    high_thr,
  output logic             ok_out,
  output rce_pkg::pix_t    edge_out,
  output logic             last_out
);
  import rce_pkg::*;

  sup_word_t sup_mem [MAX_WIDTH];

  sup_word_t sup_rd_r;
  sup_word_t sup1_r;
  pix_t      sup2_r;
  sup_in_t   sin2_r;
  pos_t      pos2_r;
  col_t      col2_r;
  pix_t      tc2_r, tup2_r, tl2_r, tr2_r;
  logic      ok_r, last_r;
  pix_t      edge_r;

  logic      kill;
  pix_t      sup_s;
  pix_t      thr;
  sup_word_t wword;

  always_comb begin
    kill  = !pos2_r.border_s && sin2_r.dir &&
            ((sin2_r.m < sin2_r.up) || (sin2_r.m < sin2_r.dn) ||
             (sin2_r.m < sin2_r.lf) || (sin2_r.m < sin2_r.rt));
    sup_s = kill ? EDGE_OFF : sin2_r.m;
    wword = '{sup_new: sup_s, sup_old: tc2_r};
    if (pos2_r.border_q) begin
      thr = tc2_r;
    end else if (tc2_r < low_thr) begin
      thr = EDGE_OFF;
    end else if (tc2_r > high_thr) begin
      thr = EDGE_ON;
    end else if ((tup2_r > high_thr) || (sup_s > high_thr) ||
                 (tl2_r > high_thr) || (tr2_r > high_thr)) begin
      thr = EDGE_ON;
    end else begin
      thr = EDGE_OFF;
    end
  end

  always_ff @(posedge clk) begin
    // A read of the column being written back in the same cycle takes the new word.
    if (acc) begin
      sup_rd_r <= (adv2 && (rd_col == col2_r)) ? wword : sup_mem[rd_col];
    end
    if (adv2) begin
      sup_mem[col2_r] <= wword;
      ok_r            <= pos2_r.out_ok;
      last_r          <= pos2_r.out_ok && pos2_r.last;
      edge_r          <= pos2_r.out_ok ? thr : EDGE_OFF;
    end
    if (adv1) begin
      sup1_r <= sup_rd_r;
      sup2_r <= sup1_r.sup_new;
      sin2_r <= sup_in;
      pos2_r <= pos1;
      col2_r <= wr_col1;
      tc2_r  <= sup1_r.sup_new;
      tup2_r <= sup1_r.sup_old;
      tl2_r  <= sup2_r;
      tr2_r  <= sup_rd_r.sup_new;
    end
  end

  assign ok_out   = ok_r;
  assign edge_out = edge_r;
  assign last_out = last_r;

endmodule

@@ src/roberts_canny_edge_stream.sv @@
// Roberts/Canny edge stream: one result per transfer in.
// Throughput is one item per clock while out_stall is low; each line store is read and
// written once per item. Results pass the pixel read, suppression and output registers.
// Reset (synchronous, rst_n low) restores the register defaults and restarts the frame;
// the line stores are not cleared.
// Depends on rce_pkg, rce_grad and rce_thr.
module roberts_canny_edge_stream (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [7:0]                     in_pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_out_valid,
  output logic [7:0]                     out_edge_value,
  output logic                           out_frame_last,
  input  logic                           cfg_we,
  input  logic [rce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rce_pkg::CFG_W-1:0]      cfg_wdata
);
  import rce_pkg::*;

  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  pix_t             low_r, high_r;
  col_t             col_r, col1_r, colp_r;
  logic [ROW_W-1:0] row_r;
  logic             v1_r, v2_r, vo_r;
  pos_t             pos1_r;

  logic             en_o, en2, en1, adv1, adv2, acc;
  logic             c0, c1, first;
  logic [ROW_W-1:0] rb, hx;
  pos_t             pos_in;
  logic             col_wrap;
  logic [WID_W-1:0] wv;
  logic [HGT_W-1:0] hv;
  pix_t             pix_in;
  sup_in_t          sup_in;

  assign en_o = !vo_r || !out_stall;
  assign adv2 = v2_r && en_o;
  assign en2  = !v2_r || en_o;
  assign adv1 = v1_r && en2;
  assign en1  = !v1_r || en2;
  assign acc  = in_valid && en1;
  assign in_stall  = !en1;
  assign out_valid = vo_r;

  // rb is the row of the previous position; gradient, suppression and output sit
  // one, two and three rows above it, all at the previous position's column.
  always_comb begin
    c0    = (col_r == '0);
    c1    = (col_r == col_t'(1));
    first = c0 && (row_r == '0);
    rb    = c0 ? row_r - ROW_W'(1) : row_r;
    hx    = {1'b0, height_r};
    pos_in.out_ok   = !first && (rb >= ROW_W'(3));
    pos_in.last     = !first && (rb >= ROW_W'(3)) && c0 && (rb == hx + ROW_W'(2));
    pos_in.border_g = (rb == ROW_W'(1)) || (rb == hx) || c0 || c1;
    pos_in.border_s = (rb == ROW_W'(2)) || (rb == hx + ROW_W'(1)) || c0 || c1;
    pos_in.border_q = (rb == ROW_W'(3)) || (rb == hx + ROW_W'(2)) || c0 || c1;
    col_wrap = ({1'b0, col_r} + WID_W'(1)) >= width_r;
    pix_in   = in_action ? EDGE_OFF : in_pixel;
    wv = cfg_wdata[WID_W-1:0];
    hv = cfg_wdata[HGT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd640;
      height_r <= 12'd480;
      low_r    <= 8'd4;
      high_r   <= 8'd10;
      col_r    <= '0;
      row_r    <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      vo_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH: begin
            width_r <= (wv < WIDTH_MIN) ? WIDTH_MIN : ((wv > WIDTH_MAX) ? WIDTH_MAX : wv);
            col_r   <= '0;
            row_r   <= '0;
          end
          REG_HEIGHT: begin
            height_r <= (hv < HEIGHT_MIN) ? HEIGHT_MIN : hv;
            col_r    <= '0;
            row_r    <= '0;
          end
          REG_LOW:  low_r  <= cfg_wdata[PIX_W-1:0];
          REG_HIGH: high_r <= cfg_wdata[PIX_W-1:0];
          default: ;
        endcase
      end else if (acc) begin
        if (pos_in.last) begin
          col_r <= '0;
          row_r <= '0;
        end else if (col_wrap) begin
          col_r <= '0;
          row_r <= row_r + ROW_W'(1);
        end else begin
          col_r <= col_r + col_t'(1);
        end
      end
      v1_r <= acc ? 1'b1 : (adv1 ? 1'b0 : v1_r);
      v2_r <= adv1 ? 1'b1 : (adv2 ? 1'b0 : v2_r);
      vo_r <= adv2 ? 1'b1 : (out_stall ? vo_r : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      col1_r <= col_r;
      pos1_r <= pos_in;
    end
    if (adv1) begin
      colp_r <= col1_r;
    end
  end

  rce_grad u_grad (
    .clk      (clk),
    .acc      (acc),
    .rd_col   (col_r),
    .pixel_in (pix_in),
    .adv1     (adv1),
    .wr_col   (colp_r),
    .border_g (pos1_r.border_g),
    .sup_in   (sup_in)
  );

  rce_thr u_thr (
    .clk      (clk),
    .acc      (acc),
    .rd_col   (col_r),
    .adv1     (adv1),
    .adv2     (adv2),
    .wr_col1  (colp_r),
    .pos1     (pos1_r),
    .sup_in   (sup_in),
    .low_thr  (low_r),
    .high_thr (high_r),
    .ok_out   (out_out_valid),
    .edge_out (out_edge_value),
    .last_out (out_frame_last)
  );

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < width_r))
    else $error("column count reached the image width");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !cfg_we && pos_in.last) |=> (col_r == '0) && (row_r == '0))
    else $error("frame did not restart after its last transfer");

  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && vo_r && out_stall) |-> in_stall)
    else $error("input taken while the pipeline is full and stalled");

  a_last_is_output: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && out_frame_last) |-> out_out_valid)
    else $error("frame end flagged on a result without an output pixel");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r <= ({1'b0, height_r} + ROW_W'(3))))
    else $error("row count ran past the frame tail");

endmodule
